// ===== hdl/olid_pkg.sv =====
`timescale 1ns / 1ps

package olid_pkg;

	localparam int CAPACITY = 16;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int DATA_W   = 32;

	localparam logic [1:0] KIND_INSERT = 2'd0;
	localparam logic [1:0] KIND_DELETE = 2'd1;
	localparam logic [1:0] KIND_READ   = 2'd2;
	localparam logic [1:0] KIND_NONE   = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_EMPTY    = 2'd1;
	localparam logic [1:0] ST_NOTFOUND = 2'd2;
	localparam logic [1:0] ST_FULL     = 2'd3;

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	typedef struct packed {
		logic accept;
		logic exec;
	} dp_cmd_t;

	typedef struct packed {
		logic emits;
		logic read_more;
	} dp_sts_t;

endpackage

// ===== hdl/olid_intf.sv =====
`timescale 1ns / 1ps

interface olid_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         kind;
	logic signed [31:0] value;

	modport source (output valid, output kind, output value, input ready);
	modport sink (input valid, input kind, input value, output ready);
endinterface

interface olid_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] entry_value;
	logic [1:0]         status;
	logic               last;

	modport source (output valid, output entry_value, output status, output last,
		input ready);
	modport sink (input valid, input entry_value, input status, input last,
		output ready);
endinterface

// ===== hdl/ordered_list_insert_delete_top.sv =====
`timescale 1ns / 1ps

// Ordered list of up to 16 signed 32-bit values, newest at the front.
// req carries one operation per transfer: kind insert, delete or readout,
// with value as the operand. rsp carries entry_value, status and last.
// Insert and delete answer with one result; readout gives one result per
// held entry, front first, last set on the final one, or a single
// list-empty result. Unused kind three is dropped with no result.
// The request is registered into kind and value; the result register is
// then loaded in the execute state, which each operation passes through
// before req is ready again. Readout reads one entry per cycle from the
// list while rsp is not stalled.
// req is ready only between operations; one held result can wait on rsp
// while the next request is taken. A stalled rsp holds the result and
// the controller waits in its execute state until the register drains.
// Reset empties the list at once; entry contents need no clearing.
module ordered_list_insert_delete_top (
	input  logic       clk,
	input  logic       arst_n,
	olid_in_if.sink    req,
	olid_out_if.source rsp
);

	olid_pkg::dp_cmd_t cmd;
	olid_pkg::dp_sts_t sts;

	olid_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	olid_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.kind        (req.kind),
		.value       (req.value),
		.entry_value (rsp.entry_value),
		.status      (rsp.status),
		.last        (rsp.last)
	);

endmodule

// ===== hdl/olid_ctrl.sv =====
`timescale 1ns / 1ps

module olid_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	input  olid_pkg::dp_sts_t sts,
	output olid_pkg::dp_cmd_t cmd
);

	olid_pkg::state_t state_q, state_d;
	logic             out_valid_q, out_valid_d;
	logic             slot_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= olid_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	assign slot_free = !out_valid_q || rsp_ready;

	always_comb begin
		state_d     = state_q;
		req_ready   = 1'b0;
		cmd.accept  = 1'b0;
		cmd.exec    = 1'b0;
		out_valid_d = out_valid_q && !rsp_ready;
		unique case (state_q)
			olid_pkg::S_IDLE: begin
				req_ready  = 1'b1;
				cmd.accept = req_valid;
				if (req_valid) begin
					state_d = olid_pkg::S_EXEC;
				end
			end
			olid_pkg::S_EXEC: begin
				// wait for the result register to drain before the next transfer
				if (slot_free) begin
					cmd.exec = 1'b1;
					if (sts.emits) begin
						out_valid_d = 1'b1;
					end
					if (!sts.read_more) begin
						state_d = olid_pkg::S_IDLE;
					end
				end
			end
			default: state_d = olid_pkg::S_IDLE;
		endcase
	end

	assign rsp_valid = out_valid_q;

endmodule

// ===== hdl/olid_dp.sv =====
`timescale 1ns / 1ps

module olid_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  olid_pkg::dp_cmd_t  cmd,
	output olid_pkg::dp_sts_t  sts,
	input  logic [1:0]         kind,
	input  logic signed [31:0] value,
	output logic signed [31:0] entry_value,
	output logic [1:0]         status,
	output logic               last
);

	logic [1:0]                     kind_q;
	logic [olid_pkg::DATA_W-1:0]    value_q;
	logic [olid_pkg::CNT_W-1:0]     count_q;
	logic [olid_pkg::IDX_W-1:0]     idx_q;
	logic [olid_pkg::DATA_W-1:0]    entries_q [olid_pkg::CAPACITY];
	logic [olid_pkg::DATA_W-1:0]    out_value_q;
	logic [1:0]                     out_status_q;
	logic                           out_last_q;

	logic [olid_pkg::CAPACITY-1:0]  match;
	logic [olid_pkg::CAPACITY-1:0]  past_match;
	logic                           found;
	logic                           full;
	logic                           empty;
	logic [olid_pkg::CNT_W-1:0]     idx_ext;
	logic                           idx_at_end;

	assign full       = (count_q == olid_pkg::CNT_W'(olid_pkg::CAPACITY));
	assign empty      = (count_q == '0);
	assign idx_ext    = olid_pkg::CNT_W'(idx_q);
	assign idx_at_end = (idx_ext + olid_pkg::CNT_W'(1) == count_q);

	// compare every held entry, then mark all places at or behind the first hit
	always_comb begin
		logic run;
		run = 1'b0;
		for (int i = 0; i < olid_pkg::CAPACITY; i++) begin
			match[i]      = (olid_pkg::CNT_W'(i) < count_q) && (entries_q[i] == value_q);
			run           = run | match[i];
			past_match[i] = run;
		end
		found = run;
	end

	assign sts.emits     = (kind_q != olid_pkg::KIND_NONE);
	assign sts.read_more = (kind_q == olid_pkg::KIND_READ) && !empty && !idx_at_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q  <= olid_pkg::KIND_NONE;
			count_q <= '0;
			idx_q   <= '0;
		end else begin
			if (cmd.accept) begin
				kind_q <= kind;
				idx_q  <= '0;
			end else if (cmd.exec) begin
				case (kind_q)
					olid_pkg::KIND_INSERT: begin
						if (!full) begin
							count_q <= count_q + olid_pkg::CNT_W'(1);
						end
					end
					olid_pkg::KIND_DELETE: begin
						if (found) begin
							count_q <= count_q - olid_pkg::CNT_W'(1);
						end
					end
					olid_pkg::KIND_READ: begin
						idx_q <= idx_q + olid_pkg::IDX_W'(1);
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			value_q <= value;
		end
		if (cmd.exec) begin
			out_value_q <= '0;
			out_last_q  <= 1'b1;
			case (kind_q)
				olid_pkg::KIND_INSERT: begin
					if (full) begin
						out_status_q <= olid_pkg::ST_FULL;
					end else begin
						out_status_q <= olid_pkg::ST_OK;
						for (int i = olid_pkg::CAPACITY - 1; i > 0; i--) begin
							entries_q[i] <= entries_q[i-1];
						end
						entries_q[0] <= value_q;
					end
				end
				olid_pkg::KIND_DELETE: begin
					if (empty) begin
						out_status_q <= olid_pkg::ST_EMPTY;
					end else if (!found) begin
						out_status_q <= olid_pkg::ST_NOTFOUND;
					end else begin
						out_status_q <= olid_pkg::ST_OK;
						// close the gap: every place from the hit on takes its successor
						for (int i = 0; i < olid_pkg::CAPACITY - 1; i++) begin
							if (past_match[i]) begin
								entries_q[i] <= entries_q[i+1];
							end
						end
					end
				end
				olid_pkg::KIND_READ: begin
					if (empty) begin
						out_status_q <= olid_pkg::ST_EMPTY;
					end else begin
						out_status_q <= olid_pkg::ST_OK;
						out_value_q  <= entries_q[idx_q];
						out_last_q   <= idx_at_end;
					end
				end
				default: out_status_q <= olid_pkg::ST_OK;
			endcase
		end
	end

	assign entry_value = signed'(out_value_q);
	assign status      = out_status_q;
	assign last        = out_last_q;

endmodule
